/* rtl/qsg_pkg.sv */
// ----------------------------------------------------------------------------
// qsg_pkg
// Shared constants for the quaternion squash gradient block.
// ----------------------------------------------------------------------------
package qsg_pkg;

    // default data format: signed Q8.16 in 24 bits
    localparam int DATA_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;

    // one lane per quaternion component
    localparam int NUM_LANES      = 4;

endpackage

/* rtl/qsg_in_if.sv */
// ----------------------------------------------------------------------------
// qsg_in_if
// Input channel: one quaternion v, its upstream gradient g and a last marker.
// ----------------------------------------------------------------------------
interface qsg_in_if import qsg_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] vec_a;
    logic signed [DATA_WIDTH-1:0] vec_b;
    logic signed [DATA_WIDTH-1:0] vec_c;
    logic signed [DATA_WIDTH-1:0] vec_d;
    logic signed [DATA_WIDTH-1:0] grad_a;
    logic signed [DATA_WIDTH-1:0] grad_b;
    logic signed [DATA_WIDTH-1:0] grad_c;
    logic signed [DATA_WIDTH-1:0] grad_d;
    logic                         last_in;

    modport source (
        output valid, vec_a, vec_b, vec_c, vec_d,
               grad_a, grad_b, grad_c, grad_d, last_in,
        input  ready
    );

    modport sink (
        input  valid, vec_a, vec_b, vec_c, vec_d,
               grad_a, grad_b, grad_c, grad_d, last_in,
        output ready
    );
endinterface

/* rtl/qsg_out_if.sv */
// ----------------------------------------------------------------------------
// qsg_out_if
// Output channel: gradient u, zero-norm flag and last marker.
// ----------------------------------------------------------------------------
interface qsg_out_if import qsg_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_a;
    logic signed [DATA_WIDTH-1:0] out_b;
    logic signed [DATA_WIDTH-1:0] out_c;
    logic signed [DATA_WIDTH-1:0] out_d;
    logic                         zero_norm;
    logic                         last_out;

    modport source (
        output valid, out_a, out_b, out_c, out_d, zero_norm, last_out,
        input  ready
    );

    modport sink (
        input  valid, out_a, out_b, out_c, out_d, zero_norm, last_out,
        output ready
    );
endinterface

/* rtl/quaternion_squash_gradient_top.sv */
// ----------------------------------------------------------------------------
// quaternion_squash_gradient_top
// Backward pass of v/(1+|v|) on one quaternion per beat, four lanes wide.
// Pipeline depth is set by the one-bit-per-stage square root and divider chains.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat waits.
// Reset clears the valid pipeline only; no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_squash_gradient_top import qsg_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qsg_in_if.sink     i_in,
    qsg_out_if.source  o_out
);

    localparam int DW   = DATA_WIDTH;
    localparam int SW   = 2 * DW + 1;
    localparam int RW   = DW + 1;
    localparam int L1W  = RW + 1;
    localparam int LLW  = 2 * DW + 3;
    localparam int PW   = 2 * DW + 2;
    localparam int DENW = 3 * DW + 5;
    localparam int HL   = (LLW + 1) / 2;
    localparam int SDW  = PW + 8 * DW + 2;
    localparam int LL   = DW + 5;
    localparam int LAT  = 3 + RW + LL;

    // pipeline advance: free output slot or beat taken downstream
    logic w_adv;
    logic [LAT-1:0] r_vld;

    assign w_adv      = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // stage 1: per-lane squares and dot-product terms
    logic signed [DW-1:0]   w_v [NUM_LANES];
    logic signed [DW-1:0]   w_g [NUM_LANES];
    logic signed [2*DW-1:0] r_sq [NUM_LANES];
    logic signed [2*DW-1:0] r_vg [NUM_LANES];
    logic signed [DW-1:0]   r_v1 [NUM_LANES];
    logic signed [DW-1:0]   r_g1 [NUM_LANES];
    logic                   r_last1;

    assign w_v[0] = i_in.vec_a;
    assign w_v[1] = i_in.vec_b;
    assign w_v[2] = i_in.vec_c;
    assign w_v[3] = i_in.vec_d;
    assign w_g[0] = i_in.grad_a;
    assign w_g[1] = i_in.grad_b;
    assign w_g[2] = i_in.grad_c;
    assign w_g[3] = i_in.grad_d;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_sq[i] <= w_v[i] * w_v[i];
                r_vg[i] <= w_v[i] * w_g[i];
                r_v1[i] <= w_v[i];
                r_g1[i] <= w_g[i];
            end
            r_last1 <= i_in.last_in;
        end
    end

    // stage 2: merge lanes into |v|^2 and v.g, pack side data
    logic [SW-1:0]          r_s;
    logic [SDW-1:0]         r_side;
    logic [SW-1:0]          n_s;
    logic signed [PW-1:0]   n_p;
    logic [8*DW-1:0]        n_vg;

    always_comb begin
        n_s  = '0;
        n_p  = '0;
        n_vg = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            n_s = n_s + SW'($unsigned(r_sq[i]));
            n_p = n_p + PW'(r_vg[i]);
            n_vg[4*DW + i*DW +: DW] = r_v1[i];
            n_vg[i*DW +: DW]        = r_g1[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s    <= n_s;
            r_side <= {n_p, n_vg, r_last1, (n_s == '0)};
        end
    end

    // square root stages, side data delayed alongside
    logic [RW-1:0]  w_root;
    logic [SDW-1:0] r_sd [RW];

    qsg_isqrt #(
        .SW (SW),
        .RW (RW)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_s    (r_s),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd[0] <= r_side;
            for (int i = 1; i < RW; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    // stage 3: L+1 and L*(L+1)
    logic [L1W-1:0]       w_l1;
    logic [L1W-1:0]       r_l1;
    logic [LLW-1:0]       r_ll1;
    logic signed [PW-1:0] r_p3;
    logic signed [DW-1:0] r_v3 [NUM_LANES];
    logic signed [DW-1:0] r_g3 [NUM_LANES];
    logic [1:0]           r_fl3;
    logic [SDW-1:0]       w_sd;

    assign w_sd = r_sd[RW-1];
    assign w_l1 = L1W'(w_root) + (L1W'(1) << FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l1  <= w_l1;
            r_ll1 <= LLW'(w_root) * LLW'(w_l1);
            r_p3  <= w_sd[2 + 8*DW +: PW];
            for (int i = 0; i < NUM_LANES; i++) begin
                r_v3[i] <= w_sd[2 + 4*DW + i*DW +: DW];
                r_g3[i] <= w_sd[2 + i*DW +: DW];
            end
            r_fl3 <= w_sd[1:0];
        end
    end

    // shared denominator L*(L+1)^2 in two steps
    logic [HL+L1W-1:0]     r_dl;
    logic [LLW-HL+L1W-1:0] r_dh;
    logic [DENW-1:0]       r_den;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dl  <= r_ll1[HL-1:0] * r_l1;
            r_dh  <= r_ll1[LLW-1:HL] * r_l1;
            r_den <= (DENW'(r_dh) << HL) + DENW'(r_dl);
        end
    end

    // component lanes
    logic signed [DW-1:0] w_u [NUM_LANES];

    genvar l;
    generate
        for (l = 0; l < NUM_LANES; l++) begin : g_lane
            qsg_lane #(
                .DATA_WIDTH (DATA_WIDTH),
                .FRAC_BITS  (FRAC_BITS)
            ) u_lane (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_ll1 (r_ll1),
                .i_p   (r_p3),
                .i_v   (r_v3[l]),
                .i_g   (r_g3[l]),
                .i_den (r_den),
                .o_u   (w_u[l])
            );
        end
    endgenerate

    // last and zero-norm flags follow the lanes
    logic [1:0] r_fl [LL];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fl[0] <= r_fl3;
            for (int i = 1; i < LL; i++) begin
                r_fl[i] <= r_fl[i-1];
            end
        end
    end

    // merge: zero norm forces the result to zero
    logic w_zero;

    assign w_zero          = r_fl[LL-1][0];
    assign o_out.valid     = r_vld[LAT-1];
    assign o_out.zero_norm = w_zero;
    assign o_out.last_out  = r_fl[LL-1][1];
    assign o_out.out_a     = w_zero ? '0 : w_u[0];
    assign o_out.out_b     = w_zero ? '0 : w_u[1];
    assign o_out.out_c     = w_zero ? '0 : w_u[2];
    assign o_out.out_d     = w_zero ? '0 : w_u[3];

endmodule

/* rtl/qsg_isqrt.sv */
// ----------------------------------------------------------------------------
// qsg_isqrt
// Pipelined integer square root, one result bit per stage (floor).
// ----------------------------------------------------------------------------
module qsg_isqrt import qsg_pkg::*; #(
    parameter int SW = 2 * DATA_WIDTH_DEF + 1,   // radicand width
    parameter int RW = DATA_WIDTH_DEF + 1        // root width, 2*(RW-1) < SW
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_s,
    output logic [RW-1:0] o_root
);

    logic [SW-1:0] r_x [RW];
    logic [SW-1:0] r_r [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            localparam logic [SW-1:0] ONE = SW'(1) << (2 * (RW - 1 - k));
            logic [SW-1:0] w_x;
            logic [SW-1:0] w_r;
            logic [SW-1:0] w_t;
            logic [SW-1:0] n_x;
            logic [SW-1:0] n_r;

            if (k == 0) begin : g_first
                assign w_x = i_s;
                assign w_r = '0;
            end else begin : g_next
                assign w_x = r_x[k-1];
                assign w_r = r_r[k-1];
            end

            // trial subtract of (root + one)
            always_comb begin
                w_t = w_r + ONE;
                if (w_x >= w_t) begin
                    n_x = w_x - w_t;
                    n_r = (w_r >> 1) + ONE;
                end else begin
                    n_x = w_x;
                    n_r = w_r >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k] <= n_x;
                    r_r[k] <= n_r;
                end
            end
        end
    endgenerate

    assign o_root = r_r[RW-1][RW-1:0];

endmodule

/* rtl/qsg_lane.sv */
// ----------------------------------------------------------------------------
// qsg_lane
// One component of the gradient: numerator, rounded long division by
// 2*L*(L+1)^2 and saturation to the signed data range.
// ----------------------------------------------------------------------------
module qsg_lane import qsg_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [2*DATA_WIDTH+2:0]              i_ll1,
    input  logic signed [2*DATA_WIDTH+1:0]       i_p,
    input  logic signed [DATA_WIDTH-1:0]         i_v,
    input  logic signed [DATA_WIDTH-1:0]         i_g,
    input  logic [3*DATA_WIDTH+4:0]              i_den,
    output logic signed [DATA_WIDTH-1:0]         o_u
);

    localparam int DW   = DATA_WIDTH;
    localparam int LLW  = 2 * DW + 3;
    localparam int PW   = 2 * DW + 2;
    localparam int DENW = 3 * DW + 5;
    localparam int HL   = (LLW + 1) / 2;
    localparam int HP   = PW / 2;
    localparam int NUMW = LLW + DW + 2;
    localparam int NW   = NUMW + FRAC_BITS + 2;
    localparam int D2W  = DENW + 1;
    localparam int XW   = NW + DW;
    localparam logic [DW-1:0] MAXPOS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MAXNEG = {1'b1, {(DW-1){1'b0}}};

    // stage a: partial products, wide operands split in halves
    logic signed [HL+DW:0]        r_pgl;
    logic signed [LLW-HL+DW:0]    r_pgh;
    logic signed [HP+DW:0]        r_ppl;
    logic signed [PW-HP+DW-1:0]   r_pph;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pgl <= $signed({1'b0, i_ll1[HL-1:0]}) * i_g;
            r_pgh <= $signed({1'b0, i_ll1[LLW-1:HL]}) * i_g;
            r_ppl <= $signed({1'b0, i_p[HP-1:0]}) * i_v;
            r_pph <= $signed(i_p[PW-1:HP]) * i_v;
        end
    end

    // stage b: numerator g*L(L+1) - v*P
    logic signed [NUMW-1:0] r_num;
    logic signed [NUMW-1:0] n_num;

    always_comb begin
        n_num = (NUMW'(r_pgh) <<< HL) + NUMW'(r_pgl)
              - (NUMW'(r_pph) <<< HP) - NUMW'(r_ppl);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
        end
    end

    // stage c: magnitude, scale and add half divisor for rounding
    logic [NW-1:0]   r_nn;
    logic [D2W-1:0]  r_d2;
    logic            r_neg;
    logic [NUMW-1:0] w_mag;

    assign w_mag = r_num[NUMW-1] ? $unsigned(-r_num) : $unsigned(r_num);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nn  <= (NW'(w_mag) << (FRAC_BITS + 1)) + NW'(i_den);
            r_d2  <= {i_den, 1'b0};
            r_neg <= r_num[NUMW-1];
        end
    end

    // stage d: quotient overflow check against divisor * 2^DW
    logic [NW-1:0]  r_on;
    logic [D2W-1:0] r_od;
    logic           r_oneg;
    logic           r_ovf;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_on   <= r_nn;
            r_od   <= r_d2;
            r_oneg <= r_neg;
            r_ovf  <= XW'(r_nn) >= (XW'(r_d2) << DW);
        end
    end

    // restoring division, one quotient bit per stage
    logic [NW-1:0]  r_rem [DW];
    logic [DW-1:0]  r_q   [DW];
    logic [D2W-1:0] r_dd  [DW];
    logic           r_ng  [DW];
    logic           r_ov  [DW];

    genvar j;
    generate
        for (j = 0; j < DW; j++) begin : g_div
            localparam int K = DW - 1 - j;
            logic [NW-1:0]  w_rem;
            logic [DW-1:0]  w_q;
            logic [D2W-1:0] w_dd;
            logic           w_ng;
            logic           w_ov;
            logic [XW-1:0]  w_sh;
            logic [NW-1:0]  n_rem;
            logic [DW-1:0]  n_q;

            if (j == 0) begin : g_first
                assign w_rem = r_on;
                assign w_q   = '0;
                assign w_dd  = r_od;
                assign w_ng  = r_oneg;
                assign w_ov  = r_ovf;
            end else begin : g_next
                assign w_rem = r_rem[j-1];
                assign w_q   = r_q[j-1];
                assign w_dd  = r_dd[j-1];
                assign w_ng  = r_ng[j-1];
                assign w_ov  = r_ov[j-1];
            end

            always_comb begin
                w_sh  = XW'(w_dd) << K;
                n_rem = w_rem;
                n_q   = w_q;
                if (XW'(w_rem) >= w_sh) begin
                    n_rem  = w_rem - w_sh[NW-1:0];
                    n_q[K] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= n_rem;
                    r_q[j]   <= n_q;
                    r_dd[j]  <= w_dd;
                    r_ng[j]  <= w_ng;
                    r_ov[j]  <= w_ov;
                end
            end
        end
    endgenerate

    // final stage: saturate and apply sign
    logic [DW-1:0] w_qf;
    logic [DW-1:0] n_mag;
    logic [DW-1:0] n_u;

    assign w_qf = r_q[DW-1];

    always_comb begin
        if (r_ng[DW-1]) begin
            n_mag = (r_ov[DW-1] || (w_qf > MAXNEG)) ? MAXNEG : w_qf;
            n_u   = DW'(0) - n_mag;
        end else begin
            n_mag = (r_ov[DW-1] || (w_qf > MAXPOS)) ? MAXPOS : w_qf;
            n_u   = n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_u <= $signed(n_u);
        end
    end

endmodule
